// File: sv/biq_pkg.sv
`default_nettype none

package biq_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int DELAY_W  = 24;
  localparam int PROD_W   = COEF_W + DELAY_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int FRAC_W   = 14;
  localparam int RND_W    = ACC_W - FRAC_W;
  localparam int STEP_W   = 3;
  localparam int INDEX_W  = 3;

  localparam logic [COEF_W-1:0] COEF_A_RESET = COEF_W'(1 << FRAC_W);
  localparam logic [STEP_W-1:0] STEP_HOME    = '0;

  typedef enum logic [INDEX_W-1:0] {
    REG_A  = 3'd0,
    REG_A1 = 3'd1,
    REG_A2 = 3'd2,
    REG_B1 = 3'd3,
    REG_B2 = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    COEF_A,
    COEF_A1,
    COEF_A2,
    COEF_B1,
    COEF_B2
  } coef_sel_t;

  typedef enum logic [1:0] {
    DATA_D0,
    DATA_D1,
    DATA_W
  } data_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_LOAD_PROD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_HOME
  } jump_t;

  typedef struct packed {
    coef_sel_t coef_sel;
    data_sel_t data_sel;
    acc_op_t   acc_op;
    logic      w_load;
    logic      y_load;
    jump_t     jump;
  } ctrl_t;

  // Microprogram. The product register trails the multiplier operands by one
  // step, so each accumulate consumes the product selected one step earlier.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t word;
    word = '{COEF_A, DATA_W, ACC_HOLD, 1'b0, 1'b0, JMP_HOME};
    case (step)
      3'd0: word = '{COEF_B1, DATA_D0, ACC_LOAD_X,    1'b0, 1'b0, JMP_WAIT_IN};
      3'd1: word = '{COEF_B2, DATA_D1, ACC_SUB,       1'b0, 1'b0, JMP_NEXT};
      3'd2: word = '{COEF_A1, DATA_D0, ACC_SUB,       1'b0, 1'b0, JMP_NEXT};
      3'd3: word = '{COEF_A2, DATA_D1, ACC_LOAD_PROD, 1'b1, 1'b0, JMP_NEXT};
      3'd4: word = '{COEF_A,  DATA_W,  ACC_ADD,       1'b0, 1'b0, JMP_NEXT};
      3'd5: word = '{COEF_A,  DATA_W,  ACC_ADD,       1'b0, 1'b0, JMP_NEXT};
      3'd6: word = '{COEF_A,  DATA_W,  ACC_HOLD,      1'b0, 1'b1, JMP_HOME};
      default: word = '{COEF_A, DATA_W, ACC_HOLD, 1'b0, 1'b0, JMP_HOME};
    endcase
    return word;
  endfunction

endpackage

`default_nettype wire

// File: sv/biq_sequencer.sv
`default_nettype none

module biq_sequencer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           out_valid,
  input  wire logic           out_ready,
  output biq_pkg::ctrl_t      issue
);

  import biq_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_t             word;
  logic              accept;
  logic              out_stall;

  assign word      = ucode(step);
  assign in_ready  = !rst && (word.jump == JMP_WAIT_IN);
  assign accept    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  always_comb begin
    issue = word;
    if (word.jump == JMP_WAIT_IN && !in_valid) begin
      issue.acc_op = ACC_HOLD;
    end
    if (out_stall) begin
      issue.y_load = 1'b0;
    end
  end

  always_comb begin
    unique case (word.jump)
      JMP_NEXT:    step_next = step + STEP_W'(1);
      JMP_WAIT_IN: step_next = accept ? step + STEP_W'(1) : step;
      JMP_HOME:    step_next = out_stall ? step : STEP_HOME;
      default:     step_next = STEP_HOME;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_HOME;
    end else begin
      step <= step_next;
    end
  end

  a_accept_advances: assert property (@(posedge clk) disable iff (rst)
    accept |=> step == STEP_HOME + STEP_W'(1))
    else $error("sequencer did not leave the home step after an input transfer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_stall |-> !issue.y_load)
    else $error("result loaded while the previous one waits for transfer");

  a_result_returns_home: assert property (@(posedge clk) disable iff (rst)
    issue.y_load |=> step == STEP_HOME)
    else $error("sequencer did not return home after loading a result");

endmodule

`default_nettype wire

// File: sv/biq_datapath.sv
`default_nettype none

module biq_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire biq_pkg::ctrl_t                 issue,
  input  wire logic                           cfg_valid,
  input  wire logic [biq_pkg::INDEX_W-1:0]    cfg_index,
  input  wire logic [biq_pkg::COEF_W-1:0]     cfg_data,
  input  wire logic signed [biq_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic signed [biq_pkg::SAMPLE_W-1:0] sample_out
);

  import biq_pkg::*;

  logic signed [COEF_W-1:0]  coef_a;
  logic signed [COEF_W-1:0]  coef_a1;
  logic signed [COEF_W-1:0]  coef_a2;
  logic signed [COEF_W-1:0]  coef_b1;
  logic signed [COEF_W-1:0]  coef_b2;
  logic signed [DELAY_W-1:0] d0;
  logic signed [DELAY_W-1:0] d1;
  logic signed [DELAY_W-1:0] w;
  logic signed [PROD_W-1:0]  product;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic signed [RND_W-1:0]   rnd;
  logic signed [COEF_W-1:0]  mul_coef;
  logic signed [DELAY_W-1:0] mul_data;
  logic signed [DELAY_W-1:0] w_sat;
  logic signed [SAMPLE_W-1:0] y_sat;

  always_comb begin
    unique case (issue.coef_sel)
      COEF_A:  mul_coef = coef_a;
      COEF_A1: mul_coef = coef_a1;
      COEF_A2: mul_coef = coef_a2;
      COEF_B1: mul_coef = coef_b1;
      COEF_B2: mul_coef = coef_b2;
      default: mul_coef = coef_a;
    endcase
  end

  always_comb begin
    unique case (issue.data_sel)
      DATA_D0: mul_data = d0;
      DATA_D1: mul_data = d1;
      DATA_W:  mul_data = w;
      default: mul_data = w;
    endcase
  end

  always_ff @(posedge clk) begin
    product <= PROD_W'(mul_coef * mul_data);
  end

  assign prod_ext = {{(ACC_W-PROD_W){product[PROD_W-1]}}, product};

  always_comb begin
    unique case (issue.acc_op)
      ACC_HOLD:      acc_next = acc;
      ACC_LOAD_X:    acc_next = {{(ACC_W-SAMPLE_W-FRAC_W){sample_in[SAMPLE_W-1]}},
                                 sample_in, {FRAC_W{1'b0}}};
      ACC_LOAD_PROD: acc_next = prod_ext;
      ACC_ADD:       acc_next = acc + prod_ext;
      ACC_SUB:       acc_next = acc - prod_ext;
      default:       acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // Round half up, then an arithmetic shift drops the fraction bits.
  assign rnd_sum = acc + (ACC_W'(1) <<< (FRAC_W - 1));
  assign rnd     = rnd_sum[ACC_W-1:FRAC_W];

  always_comb begin
    if (rnd[RND_W-1:DELAY_W-1] == '0 || rnd[RND_W-1:DELAY_W-1] == '1) begin
      w_sat = rnd[DELAY_W-1:0];
    end else begin
      w_sat = {rnd[RND_W-1], {(DELAY_W-1){!rnd[RND_W-1]}}};
    end
    if (rnd[RND_W-1:SAMPLE_W-1] == '0 || rnd[RND_W-1:SAMPLE_W-1] == '1) begin
      y_sat = rnd[SAMPLE_W-1:0];
    end else begin
      y_sat = {rnd[RND_W-1], {(SAMPLE_W-1){!rnd[RND_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (issue.w_load) begin
      w <= w_sat;
    end
    if (issue.y_load) begin
      sample_out <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d0 <= '0;
      d1 <= '0;
    end else if (issue.y_load) begin
      d1 <= d0;
      d0 <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue.y_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a  <= COEF_A_RESET;
      coef_a1 <= '0;
      coef_a2 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_A:   coef_a  <= cfg_data;
        REG_A1:  coef_a1 <= cfg_data;
        REG_A2:  coef_a2 <= cfg_data;
        REG_B1:  coef_b1 <= cfg_data;
        REG_B2:  coef_b2 <= cfg_data;
        default: ;
      endcase
    end
  end

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    issue.y_load |=> out_valid)
    else $error("loaded result is not offered for transfer");

  a_delay_shift: assert property (@(posedge clk) disable iff (rst)
    issue.y_load |=> d1 == $past(d0))
    else $error("delay line did not shift with the result");

  a_feedback_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index == REG_B1 |=> coef_b1 == $past(cfg_data))
    else $error("feedback coefficient write was lost");

endmodule

`default_nettype wire

// File: sv/biquad_iir_filter.sv
`default_nettype none

// Second-order IIR section in direct form II for signed 16-bit samples.
// Each transfer on the input channel yields exactly one saturated 16-bit
// result. A short microprogram drives one 18x24 multiplier and one
// accumulator through the five products. Items do not overlap: a new input
// is taken only at the home step, after the previous item has loaded its
// result. The next input is taken while a result still
// waits for its transfer; the result step holds until the output register
// is free. Coefficients are signed Q3.14 (16384 is 1.0) at register indexes
// 0 to 4: a, a1, a2, b1, b2; writes to other indexes are dropped. After reset
// a is 1.0 and the rest are zero, so samples pass through unchanged.
// Coefficients should be written only while no item is in flight.
module biquad_iir_filter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [biq_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [biq_pkg::SAMPLE_W-1:0]      sample_out,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [biq_pkg::INDEX_W-1:0]         cfg_index,
  input  wire logic [biq_pkg::COEF_W-1:0]          cfg_data
);

  import biq_pkg::*;

  ctrl_t issue;

  assign cfg_ready = !rst;

  biq_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .issue     (issue)
  );

  biq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .sample_out (sample_out)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import biq_pkg::*;

  localparam int NUM_COEFS = REG_B2 + 1;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 145;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT = 32;
  localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  logic signed [SAMPLE_W-1:0] samples_due [$];
  logic signed [SAMPLE_W-1:0] expected_out [$];
  logic signed [SAMPLE_W-1:0] want;
  logic signed [COEF_W-1:0] gain [NUM_COEFS] = '{COEF_A_RESET, '0, '0, '0, '0};
  logic signed [DELAY_W-1:0] delay_w0 = '0;
  logic signed [DELAY_W-1:0] delay_w1 = '0;
  logic in_taken = 1'b0;
  logic steady = 1'b0;
  logic failed = 1'b0;
  int cycle_count = 0;

  biquad_iir_filter uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint round_sat(input longint acc, input longint lo, input longint hi);
    longint v;
    v = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    if (v < lo) begin
      v = lo;
    end else if (v > hi) begin
      v = hi;
    end
    return v;
  endfunction

  // Advances the filter state by one sample and returns the expected output.
  function automatic logic signed [SAMPLE_W-1:0] filter_step(
    input logic signed [SAMPLE_W-1:0] x
  );
    longint w;
    longint y;
    w = round_sat((longint'(x) <<< FRAC_W)
                  - longint'(gain[REG_B1]) * longint'(delay_w0)
                  - longint'(gain[REG_B2]) * longint'(delay_w1),
                  -(longint'(1) <<< (DELAY_W - 1)), (longint'(1) <<< (DELAY_W - 1)) - 1);
    y = round_sat(longint'(gain[REG_A]) * w
                  + longint'(gain[REG_A1]) * longint'(delay_w0)
                  + longint'(gain[REG_A2]) * longint'(delay_w1),
                  -(longint'(1) <<< (SAMPLE_W - 1)), (longint'(1) <<< (SAMPLE_W - 1)) - 1);
    delay_w1 = delay_w0;
    delay_w0 = DELAY_W'(w);
    return SAMPLE_W'(y);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      return EDGE_SAMPLES[$urandom_range(3)];
    end else if (roll < 40) begin
      return SAMPLE_W'(int'($urandom_range(1023)) - 512);
    end
    return SAMPLE_W'($urandom);
  endfunction

  task automatic write_coef(input logic [INDEX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cfg_valid <= 1'b0;
      @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_COEFS) begin
      gain[idx] = val;
    end
  endtask

  // Writes all five gains, then one write to an unused index that must be dropped.
  task automatic load_coefs(input logic [COEF_W-1:0] a, a1, a2, b1, b2);
    write_coef(REG_A, a);
    write_coef(REG_A1, a1);
    write_coef(REG_A2, a2);
    write_coef(REG_B1, b1);
    write_coef(REG_B2, b2);
    write_coef(INDEX_W'($urandom_range(NUM_COEFS, (1 << INDEX_W) - 1)), COEF_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (samples_due.size() != 0 || in_valid || expected_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (samples_due.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        sample_in <= samples_due.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && (steady || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: sample_out %0d transferred with no result expected", $time, sample_out);
          failed <= 1'b1;
        end else begin
          want = expected_out.pop_front();
          if (sample_out !== want) begin
            $display("%0t: sample_out expected %0d, got %0d", $time, want, sample_out);
            failed <= 1'b1;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_out.push_back(filter_step(sample_in));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int b1;
    int b2;
    int span;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset the section must pass samples through unchanged.
    samples_due = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555,
                    16'shAAAA, 16'sd12345};
    drain();

    // A stable lowpass driven by an impulse of each polarity.
    load_coefs(18'sd1000, 18'sd2000, 18'sd1000, -18'sd26000, 18'sd10700);
    samples_due = '{16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000};
    drain();

    // Largest gains: the output saturates at once and the stored feedback soon does.
    load_coefs(18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071);
    samples_due = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                    16'sh8000};
    drain();

    load_coefs(-18'sd131072, -18'sd131072, -18'sd131072, -18'sd131072, -18'sd131072);
    samples_due = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000};
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      steady = (phase == 3);
      if (phase % 2 == 0) begin
        b2 = $urandom_range(15000);
        span = 16384 + b2 - 512;
        b1 = int'($urandom_range(2 * span)) - span;
        load_coefs(COEF_W'(int'($urandom_range(65535)) - 32768),
                   COEF_W'(int'($urandom_range(65535)) - 32768),
                   COEF_W'(int'($urandom_range(65535)) - 32768),
                   COEF_W'(b1), COEF_W'(b2));
      end else begin
        load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                   COEF_W'($urandom), COEF_W'($urandom));
      end
      repeat (PHASE_ITEMS) samples_due.push_back(pick_sample());
      drain();
      steady = 1'b0;
    end

    if (!failed) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
